// ===== design/ida_pkg.sv =====
package ida_pkg;

  localparam int MAX_IDS    = 64;
  localparam int REF_WIDTH  = 8;
  localparam int TAG_WIDTH  = 32;

  localparam int IDX_W      = $clog2(MAX_IDS);
  localparam int CNT_W      = $clog2(MAX_IDS + 1);
  localparam int KIND_W     = 3;
  localparam int ID_W       = 16;
  localparam int STATUS_W   = 3;
  localparam int COUNT_W    = 7;
  localparam int CLEANUP_W  = 8;
  localparam int LIMIT_W    = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [ID_W-1:0]      FIRST_ID_RST   = ID_W'(100);
  localparam logic [LIMIT_W-1:0]   POOL_LIMIT_RST = LIMIT_W'(64);
  localparam logic [REF_WIDTH-1:0] REF_MAX        = '1;
  localparam logic [CLEANUP_W-1:0] CLEANUP_MAX    = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ID   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_LIMIT = CFG_IDX_W'(1);

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC       = 3'd0,
    KIND_RELEASE     = 3'd1,
    KIND_LOOKUP_ID   = 3'd2,
    KIND_LOOKUP_TAG  = 3'd3,
    KIND_SET_TAG     = 3'd4,
    KIND_BEGIN_CLEAN = 3'd5,
    KIND_END_CLEAN   = 3'd6
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_NOT_ACTIVE  = 3'd1,
    ST_EXHAUSTED   = 3'd2,
    ST_WAIT        = 3'd3,
    ST_REF_FULL    = 3'd4,
    ST_CLEANUP_ERR = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_POP,
    S_FETCH,
    S_SCAN,
    S_EXEC
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load_item;
    logic rd_slot;
    logic rd_stack;
    logic capture_pop;
    logic capture_entry;
    logic scan_start;
    logic scan_step;
    logic exec;
  } ida_cmd_t;

  // datapath -> controller
  typedef struct packed {
    kind_e kind;
    logic  cleanup_nz;
    logic  stack_nonempty;
    logic  slot_ok;
    logic  scan_hit;
    logic  scan_miss;
    logic  out_free;
  } ida_stat_t;

endpackage

// ===== design/ida_req_if.sv =====
interface ida_req_if;
  logic                        valid;
  logic                        ready;
  logic [ida_pkg::KIND_W-1:0]    kind;
  logic [ida_pkg::ID_W-1:0]      id;
  logic [ida_pkg::TAG_WIDTH-1:0] thread_tag;

  modport source (output valid, kind, id, thread_tag, input ready);
  modport sink   (input valid, kind, id, thread_tag, output ready);
endinterface

// ===== design/ida_rsp_if.sv =====
interface ida_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ida_pkg::STATUS_W-1:0]  status;
  logic [ida_pkg::ID_W-1:0]      result_id;
  logic [ida_pkg::TAG_WIDTH-1:0] result_tag;
  logic [ida_pkg::REF_WIDTH-1:0] entry_refs;
  logic                          freed;
  logic [ida_pkg::COUNT_W-1:0]   active_count;
  logic [ida_pkg::COUNT_W-1:0]   free_count;
  logic [ida_pkg::COUNT_W-1:0]   created_count;
  logic [ida_pkg::CLEANUP_W-1:0] cleanups_pending;

  modport source (output valid, status, result_id, result_tag, entry_refs, freed,
                  active_count, free_count, created_count, cleanups_pending,
                  input ready);
  modport sink   (input valid, status, result_id, result_tag, entry_refs, freed,
                  active_count, free_count, created_count, cleanups_pending,
                  output ready);
endinterface

// ===== design/ida_cfg_if.sv =====
interface ida_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ida_pkg::CFG_IDX_W-1:0]  index;
  logic [ida_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/refcounted_id_allocator.sv =====
// Channel   Dir  Handshake     Payload
// req_i     in   valid/ready   kind, id, thread_tag
// rsp_o     out  valid/ready   status, result_id, result_tag, entry_refs, freed, counts
// cfg_i     in   valid/ready   index (0 first_id, 1 pool_limit), data
//
// One transaction at a time. After accept, the check step goes straight to commit when no
// entry is read, through a pop or fetch step when an entry or the top of the free stack is
// read, and through a scan for a lookup by tag, which walks the tag memory one entry per cycle.
// Reset clears counters and in-use bits and sets config to its defaults; the memories hold no reset.
// A stalled result holds the block in its commit step until it is taken.
module refcounted_id_allocator (
  input logic       clk_i,
  input logic       rst_ni,
  ida_req_if.sink   req_i,
  ida_rsp_if.source rsp_o,
  ida_cfg_if.sink   cfg_i
);
  import ida_pkg::*;

  ida_cmd_t  cmd;
  ida_stat_t stat;
  logic      req_ready;

  ida_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ida_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .kind_i (req_i.kind),
    .id_i   (req_i.id),
    .tag_i  (req_i.thread_tag),
    .cfg_i  (cfg_i),
    .rsp_o  (rsp_o),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

  assign req_i.ready = req_ready;

endmodule

// ===== design/ida_ram.sv =====
module ida_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/ida_ctrl.sv =====
module ida_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  ida_pkg::ida_stat_t stat_i,
  output ida_pkg::ida_cmd_t  cmd_o
);
  import ida_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q) inside
      S_IDLE: begin
        if (req_valid_i) state_d = S_CHECK;
      end
      S_CHECK: begin
        unique case (stat_i.kind) inside
          KIND_ALLOC: begin
            state_d = (!stat_i.cleanup_nz && stat_i.stack_nonempty) ? S_POP : S_EXEC;
          end
          KIND_RELEASE, KIND_LOOKUP_ID, KIND_SET_TAG: begin
            state_d = stat_i.slot_ok ? S_FETCH : S_EXEC;
          end
          KIND_LOOKUP_TAG: state_d = S_SCAN;
          default:         state_d = S_EXEC;
        endcase
      end
      S_POP, S_FETCH: state_d = S_EXEC;
      S_SCAN: begin
        if (stat_i.scan_hit || stat_i.scan_miss) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o     = 1'b1;
        cmd_o.load_item = req_valid_i;
      end
      S_CHECK: begin
        unique case (stat_i.kind) inside
          KIND_ALLOC: begin
            cmd_o.rd_stack = !stat_i.cleanup_nz && stat_i.stack_nonempty;
          end
          KIND_RELEASE, KIND_LOOKUP_ID, KIND_SET_TAG: begin
            cmd_o.rd_slot = stat_i.slot_ok;
          end
          KIND_LOOKUP_TAG: cmd_o.scan_start = 1'b1;
          default: ;
        endcase
      end
      S_POP:   cmd_o.capture_pop   = 1'b1;
      S_FETCH: cmd_o.capture_entry = 1'b1;
      S_SCAN: begin
        cmd_o.scan_step     = 1'b1;
        cmd_o.capture_entry = stat_i.scan_hit;
      end
      S_EXEC:  cmd_o.exec = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

// ===== design/ida_dp.sv =====
module ida_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ida_pkg::KIND_W-1:0]    kind_i,
  input  logic [ida_pkg::ID_W-1:0]      id_i,
  input  logic [ida_pkg::TAG_WIDTH-1:0] tag_i,
  ida_cfg_if.sink                       cfg_i,
  ida_rsp_if.source                     rsp_o,
  input  ida_pkg::ida_cmd_t             cmd_i,
  output ida_pkg::ida_stat_t            stat_o
);
  import ida_pkg::*;

  // configuration
  logic [ID_W-1:0]    first_id_q;
  logic [LIMIT_W-1:0] pool_limit_q;

  // current item
  kind_e               kind_q;
  logic [ID_W-1:0]      id_q;
  logic [TAG_WIDTH-1:0] tag_q;
  logic [IDX_W-1:0]     slot_q;
  logic                 found_q;
  logic [REF_WIDTH-1:0] cur_rc_q;
  logic [TAG_WIDTH-1:0] cur_tag_q;

  // tag search
  logic [CNT_W-1:0] scan_idx_q;
  logic             cmp_valid_q;
  logic [IDX_W-1:0] cmp_idx_q;
  logic             scan_issue;
  logic             scan_hit;

  // pool state
  logic [CNT_W-1:0]     free_top_q, free_top_d;
  logic [CNT_W-1:0]     created_q, created_d;
  logic [CNT_W-1:0]     active_q, active_d;
  logic [CLEANUP_W-1:0] cleanup_q, cleanup_d;
  logic [MAX_IDS-1:0]   in_use_q, in_use_d;

  // result register
  logic                 out_valid_q;
  status_e              out_status_q;
  logic [ID_W-1:0]      out_id_q;
  logic [TAG_WIDTH-1:0] out_tag_q;
  logic [REF_WIDTH-1:0] out_rc_q;
  logic                 out_freed_q;
  logic [CNT_W-1:0]     out_active_q, out_free_q, out_created_q;
  logic [CLEANUP_W-1:0] out_cleanup_q;

  // id decode
  logic [ID_W-1:0]   id_diff;
  logic              slot_ok;
  logic [ID_W:0]     create_sum;
  logic              can_create;

  // step results
  status_e              res_status;
  logic                 res_hit;
  logic [IDX_W-1:0]     res_slot;
  logic [TAG_WIDTH-1:0] res_tag;
  logic [REF_WIDTH-1:0] res_rc;
  logic                 res_freed;
  logic [ID_W-1:0]      res_id;

  // memory ports
  logic                 rc_we, tag_we, stk_we;
  logic [REF_WIDTH-1:0] rc_wdata, rc_rdata;
  logic [TAG_WIDTH-1:0] tag_wdata, tag_rdata;
  logic [IDX_W-1:0]     stk_rdata;
  logic                 ent_re;
  logic [IDX_W-1:0]     ent_raddr;
  logic [IDX_W-1:0]     stk_raddr;

  assign id_diff    = id_q - first_id_q;
  assign slot_ok    = (id_q >= first_id_q) && (int'(id_diff) < int'(created_q))
                      && in_use_q[id_diff[IDX_W-1:0]];
  assign create_sum = (ID_W+1)'(first_id_q) + (ID_W+1)'(created_q);
  assign can_create = (int'(created_q) < int'(pool_limit_q))
                      && (int'(created_q) < MAX_IDS) && !create_sum[ID_W];

  assign scan_issue = scan_idx_q < created_q;
  assign scan_hit   = cmp_valid_q && in_use_q[cmp_idx_q] && (tag_rdata == tag_q);

  assign stat_o.kind           = kind_q;
  assign stat_o.cleanup_nz     = cleanup_q != '0;
  assign stat_o.stack_nonempty = free_top_q != '0;
  assign stat_o.slot_ok        = slot_ok;
  assign stat_o.scan_hit       = scan_hit;
  assign stat_o.scan_miss      = !cmp_valid_q && !scan_issue;
  assign stat_o.out_free       = !out_valid_q || rsp_o.ready;

  assign ent_re    = cmd_i.rd_slot || (cmd_i.scan_step && scan_issue);
  assign ent_raddr = cmd_i.rd_slot ? id_diff[IDX_W-1:0] : scan_idx_q[IDX_W-1:0];
  assign stk_raddr = IDX_W'(free_top_q - CNT_W'(1));

  ida_ram #(.WIDTH(REF_WIDTH), .DEPTH(MAX_IDS)) u_rc_ram (
    .clk_i   (clk_i),
    .we_i    (rc_we),
    .waddr_i (res_slot),
    .wdata_i (rc_wdata),
    .re_i    (ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (rc_rdata)
  );

  ida_ram #(.WIDTH(TAG_WIDTH), .DEPTH(MAX_IDS)) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (res_slot),
    .wdata_i (tag_wdata),
    .re_i    (ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (tag_rdata)
  );

  ida_ram #(.WIDTH(IDX_W), .DEPTH(MAX_IDS)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (free_top_q[IDX_W-1:0]),
    .wdata_i (res_slot),
    .re_i    (cmd_i.rd_stack),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // Commit of one transaction; only active while cmd_i.exec is high.
  always_comb begin
    res_status = ST_OK;
    res_hit    = 1'b0;
    res_slot   = slot_q;
    res_tag    = cur_tag_q;
    res_rc     = cur_rc_q;
    res_freed  = 1'b0;
    free_top_d = free_top_q;
    created_d  = created_q;
    active_d   = active_q;
    cleanup_d  = cleanup_q;
    in_use_d   = in_use_q;
    rc_we      = 1'b0;
    rc_wdata   = cur_rc_q;
    tag_we     = 1'b0;
    tag_wdata  = '0;
    stk_we     = 1'b0;
    if (cmd_i.exec) begin
      case (kind_q) inside
        KIND_ALLOC: begin
          if (cleanup_q != '0) begin
            res_status = ST_WAIT;
          end else if (found_q) begin
            free_top_d = free_top_q - CNT_W'(1);
            res_hit    = 1'b1;
          end else if (can_create) begin
            res_slot  = created_q[IDX_W-1:0];
            created_d = created_q + CNT_W'(1);
            res_hit   = 1'b1;
          end else begin
            res_status = ST_EXHAUSTED;
          end
          if (res_hit) begin
            in_use_d[res_slot] = 1'b1;
            rc_we    = 1'b1;
            rc_wdata = REF_WIDTH'(1);
            tag_we   = 1'b1;
            res_tag  = '0;
            res_rc   = REF_WIDTH'(1);
            active_d = active_q + CNT_W'(1);
          end
        end
        KIND_RELEASE: begin
          if (!found_q) begin
            res_status = ST_NOT_ACTIVE;
          end else if (cur_rc_q > REF_WIDTH'(1)) begin
            res_hit  = 1'b1;
            rc_we    = 1'b1;
            rc_wdata = cur_rc_q - REF_WIDTH'(1);
            res_rc   = rc_wdata;
          end else begin
            res_hit   = 1'b1;
            res_freed = 1'b1;
            rc_we     = 1'b1;
            rc_wdata  = '0;
            tag_we    = 1'b1;
            res_rc    = '0;
            res_tag   = '0;
            in_use_d[res_slot] = 1'b0;
            if (int'(free_top_q) < MAX_IDS) begin
              stk_we     = 1'b1;
              free_top_d = free_top_q + CNT_W'(1);
            end
            if (active_q != '0) active_d = active_q - CNT_W'(1);
          end
        end
        KIND_LOOKUP_ID, KIND_LOOKUP_TAG: begin
          if (!found_q) begin
            res_status = ST_NOT_ACTIVE;
          end else if (cur_rc_q == REF_MAX) begin
            res_hit    = 1'b1;
            res_status = ST_REF_FULL;
          end else begin
            res_hit  = 1'b1;
            rc_we    = 1'b1;
            rc_wdata = cur_rc_q + REF_WIDTH'(1);
            res_rc   = rc_wdata;
          end
        end
        KIND_SET_TAG: begin
          if (!found_q) begin
            res_status = ST_NOT_ACTIVE;
          end else begin
            res_hit   = 1'b1;
            tag_we    = 1'b1;
            tag_wdata = tag_q;
            res_tag   = tag_q;
          end
        end
        KIND_BEGIN_CLEAN: begin
          if (cleanup_q == CLEANUP_MAX) res_status = ST_CLEANUP_ERR;
          else cleanup_d = cleanup_q + CLEANUP_W'(1);
        end
        KIND_END_CLEAN: begin
          if (cleanup_q == '0) res_status = ST_CLEANUP_ERR;
          else cleanup_d = cleanup_q - CLEANUP_W'(1);
        end
        default: ;
      endcase
    end
  end

  assign res_id = first_id_q + ID_W'(res_slot);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_id_q   <= FIRST_ID_RST;
      pool_limit_q <= POOL_LIMIT_RST;
      free_top_q   <= '0;
      created_q    <= '0;
      active_q     <= '0;
      cleanup_q    <= '0;
      in_use_q     <= '0;
      found_q      <= 1'b0;
      cmp_valid_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          CFG_FIRST_ID:   first_id_q   <= cfg_i.data[ID_W-1:0];
          CFG_POOL_LIMIT: pool_limit_q <= cfg_i.data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      free_top_q <= free_top_d;
      created_q  <= created_d;
      active_q   <= active_d;
      cleanup_q  <= cleanup_d;
      in_use_q   <= in_use_d;
      if (cmd_i.load_item) begin
        found_q <= 1'b0;
      end else if (cmd_i.capture_pop || cmd_i.capture_entry) begin
        found_q <= 1'b1;
      end
      if (cmd_i.scan_start) begin
        cmp_valid_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        cmp_valid_q <= scan_issue;
      end
      if (cmd_i.exec) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      kind_q <= kind_e'(kind_i);
      id_q   <= id_i;
      tag_q  <= tag_i;
    end
    if (cmd_i.rd_slot) slot_q <= id_diff[IDX_W-1:0];
    if (cmd_i.capture_pop) slot_q <= stk_rdata;
    if (cmd_i.scan_step && scan_hit) slot_q <= cmp_idx_q;
    if (cmd_i.capture_entry) begin
      cur_rc_q  <= rc_rdata;
      cur_tag_q <= tag_rdata;
    end
    if (cmd_i.scan_start) begin
      scan_idx_q <= '0;
    end else if (cmd_i.scan_step && scan_issue) begin
      scan_idx_q <= scan_idx_q + CNT_W'(1);
      cmp_idx_q  <= scan_idx_q[IDX_W-1:0];
    end
    if (cmd_i.exec) begin
      out_status_q  <= res_status;
      out_id_q      <= res_hit ? res_id : '0;
      out_tag_q     <= res_hit ? res_tag : '0;
      out_rc_q      <= res_hit ? res_rc : '0;
      out_freed_q   <= res_freed;
      out_active_q  <= active_d;
      out_free_q    <= free_top_d;
      out_created_q <= created_d;
      out_cleanup_q <= cleanup_d;
    end
  end

  assign cfg_i.ready = 1'b1;

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.status           = out_status_q;
  assign rsp_o.result_id        = out_id_q;
  assign rsp_o.result_tag       = out_tag_q;
  assign rsp_o.entry_refs       = out_rc_q;
  assign rsp_o.freed            = out_freed_q;
  assign rsp_o.active_count     = COUNT_W'(out_active_q);
  assign rsp_o.free_count       = COUNT_W'(out_free_q);
  assign rsp_o.created_count    = COUNT_W'(out_created_q);
  assign rsp_o.cleanups_pending = out_cleanup_q;

endmodule
